// File: rtl/core/nwa_pkg.sv
// Shared types, constants and helper functions for the automaton word acceptor.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package nwa_pkg;

  // Automaton and table sizes.
  localparam int NumStates = 16;
  localparam int MaxEdges  = 64;

  // Field widths fixed by the item layout.
  localparam int ModeW   = 2;
  localparam int StateW  = 4;
  localparam int LetterW = 8;
  localparam int SetW    = 16;

  // Configuration port.
  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 16;

  // Edge table addressing.
  localparam int EdgeIdxW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int EdgeCntW = $clog2(MaxEdges + 1);

  // Depth of the command queue between front and back.
  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  // Item modes; the fourth code means nothing and is dropped.
  typedef enum logic [ModeW-1:0] {
    MODE_ADD = 2'd0,
    MODE_SYM = 2'd1,
    MODE_CLR = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_START_STATE = 1'b0,
    CFG_FINAL_MASK  = 1'b1
  } cfg_idx_e;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  // One classified command handed from the front to the back.
  typedef struct packed {
    mode_e              op;
    logic [StateW-1:0]  from_state;
    logic [StateW-1:0]  to_state;
    logic [LetterW-1:0] letter;
    logic               last;
  } cmd_t;

  // One stored transition.
  typedef struct packed {
    logic [StateW-1:0]  src;
    logic [StateW-1:0]  tgt;
    logic [LetterW-1:0] letter;
  } edge_t;

  // True when the state number lies inside the automaton.
  function automatic logic state_ok(input logic [StateW-1:0] s);
    return (int'(s) < NumStates);
  endfunction

  // One-hot set bit for a state, empty for a state outside the automaton.
  function automatic logic [SetW-1:0] state_bit(input logic [StateW-1:0] s);
    logic [SetW-1:0] b;
    b = '0;
    if (state_ok(s)) begin
      b[s] = 1'b1;
    end
    return b;
  endfunction

endpackage

// File: rtl/core/nfa_word_acceptor_core.sv
// Nondeterministic automaton word acceptor: queue-style input and result
// channels, a plain configuration write port. Depends on nwa_pkg, nwa_front
// and nwa_back.
//
// Usage: items are pushed with push_i while full_o is low. Mode 0 appends a
// transition (from, to, letter) to a table of up to 64 entries, mode 2 empties
// the table, mode 1 feeds one word symbol, with last_i on its final symbol.
// A word's final symbol yields one item on the result side: accepted_o is
// valid while empty_o is low and is removed with pop_i.
// Timing: commands pass through a two-entry queue to the table sequencer.
// Adding or clearing is taken straight from the idle state; for a symbol the
// sequencer walks every stored transition, reading the table memory one
// entry per cycle through its single read port, and then passes through
// its done state. Configuration (start state at index 0, final mask at
// index 1) is written with cfg_we_i; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Reset clears the table count, the active set, both registers and the
// queues; the table contents need no clearing.
// A stalled receiver holds the single result slot; the sequencer then waits
// at the end of the next word, the queue fills and full_o rises.
`timescale 1ns / 1ps

module nfa_word_acceptor_core import nwa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [ModeW-1:0]    mode_i,
  input  logic [StateW-1:0]   from_state_i,
  input  logic [StateW-1:0]   to_state_i,
  input  logic [LetterW-1:0]  letter_i,
  input  logic                last_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic                accepted_o,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Item intake and command queue.
  nwa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .mode_i       (mode_i),
    .from_state_i (from_state_i),
    .to_state_i   (to_state_i),
    .letter_i     (letter_i),
    .last_i       (last_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  // Table sequencer and result slot.
  nwa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .accepted_o  (accepted_o)
  );

endmodule

// File: rtl/core/nwa_front.sv
// Front end: accepts input items, drops the ones with no effect and queues
// the rest as commands for the back end. Depends on nwa_pkg.
`timescale 1ns / 1ps

module nwa_front import nwa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [StateW-1:0]  from_state_i,
  input  logic [StateW-1:0]  to_state_i,
  input  logic [LetterW-1:0] letter_i,
  input  logic               last_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_ready_i
);

  cmd_t               fifo_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0] cnt_q, cnt_d;
  logic               keep;
  logic               enq;
  logic               deq;
  cmd_t               cmd_in;

  // Classify the item: unused modes and transitions on unknown states vanish.
  always_comb begin
    keep = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_ADD: keep = state_ok(from_state_i) && state_ok(to_state_i);
      MODE_SYM: keep = 1'b1;
      MODE_CLR: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  assign cmd_in.op         = mode_e'(mode_i);
  assign cmd_in.from_state = from_state_i;
  assign cmd_in.to_state   = to_state_i;
  assign cmd_in.letter     = letter_i;
  assign cmd_in.last       = last_i;

  assign full_o      = (cnt_q == CmdCntW'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign enq = push_i && !full_o && keep;
  assign deq = cmd_valid_o && cmd_ready_i;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (enq) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: rtl/core/nwa_back.sv
// Back end: holds the edge table, the configuration registers and the active
// state set, walks the table once per symbol and drives the result slot.
// Depends on nwa_pkg.
`timescale 1ns / 1ps

module nwa_back import nwa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_ready_o,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic                accepted_o
);

  back_state_e         state_q, state_d;
  logic [EdgeCntW-1:0] edge_cnt_q;
  logic [SetW-1:0]     active_q;
  logic [SetW-1:0]     next_set_q;
  logic                in_word_q;
  logic [LetterW-1:0]  letter_q;
  logic                last_q;
  logic [EdgeIdxW-1:0] rd_idx_q;
  logic                res_valid_q;
  logic                res_acc_q;
  logic [StateW-1:0]   start_state_q;
  logic [SetW-1:0]     final_mask_q;

  edge_t               edge_mem [MaxEdges];
  edge_t               rd_data_q;

  logic                take_add;
  logic                take_clr;
  logic                take_sym;
  logic                last_entry;
  logic                edge_hit;
  logic                mem_we;
  logic                scan_start;
  logic                scan_step;
  logic                finish;
  logic                res_load;
  logic [EdgeIdxW-1:0] rd_addr;
  edge_t               wr_edge;

  assign take_add = (state_q == BK_IDLE) && cmd_valid_i && (cmd_i.op == MODE_ADD);
  assign take_clr = (state_q == BK_IDLE) && cmd_valid_i && (cmd_i.op == MODE_CLR);
  assign take_sym = (state_q == BK_IDLE) && cmd_valid_i && (cmd_i.op == MODE_SYM);

  // The entry just read is the last one stored.
  assign last_entry = ((EdgeCntW'(rd_idx_q) + 1'b1) >= edge_cnt_q);

  // An edge fires when its letter matches and its source is active.
  assign edge_hit = (rd_data_q.letter == letter_q) &&
                    ((active_q & state_bit(rd_data_q.src)) != '0);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take_sym) begin
          state_d = (edge_cnt_q == '0) ? BK_DONE : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (last_entry) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!last_q || !res_valid_q || pop_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    scan_start  = 1'b0;
    scan_step   = 1'b0;
    finish      = 1'b0;
    res_load    = 1'b0;
    rd_addr     = '0;
    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        mem_we      = take_add && (edge_cnt_q != EdgeCntW'(MaxEdges));
        scan_start  = take_sym;
        rd_addr     = '0;
      end
      BK_SCAN: begin
        scan_step = 1'b1;
        rd_addr   = rd_idx_q + 1'b1;
      end
      BK_DONE: begin
        finish   = !last_q || !res_valid_q || pop_i;
        res_load = last_q && finish;
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  // Word state, table fill count and result slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      edge_cnt_q  <= '0;
      active_q    <= '0;
      in_word_q   <= 1'b0;
      res_valid_q <= 1'b0;
      res_acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        edge_cnt_q <= edge_cnt_q + 1'b1;
      end else if (take_clr) begin
        edge_cnt_q <= '0;
      end
      if (scan_start && !in_word_q) begin
        active_q <= state_bit(start_state_q);
      end else if (finish) begin
        active_q <= next_set_q;
      end
      if (finish) begin
        in_word_q <= !last_q;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
        res_acc_q   <= ((next_set_q & final_mask_q) != '0);
      end else if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Symbol being processed and the set it builds.
  always_ff @(posedge clk_i) begin
    if (scan_start) begin
      letter_q   <= cmd_i.letter;
      last_q     <= cmd_i.last;
      rd_idx_q   <= rd_addr;
      next_set_q <= '0;
    end else if (scan_step) begin
      rd_idx_q <= rd_addr;
      if (edge_hit) begin
        next_set_q <= next_set_q | state_bit(rd_data_q.tgt);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= '0;
      final_mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_START_STATE: start_state_q <= cfg_wdata_i[StateW-1:0];
        CFG_FINAL_MASK:  final_mask_q  <= cfg_wdata_i[SetW-1:0];
        default:         start_state_q <= start_state_q;
      endcase
    end
  end

  assign wr_edge.src    = cmd_i.from_state;
  assign wr_edge.tgt    = cmd_i.to_state;
  assign wr_edge.letter = cmd_i.letter;

  // Edge table: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem[edge_cnt_q[EdgeIdxW-1:0]] <= wr_edge;
    end
    rd_data_q <= edge_mem[rd_addr];
  end

  assign empty_o    = !res_valid_q;
  assign accepted_o = res_acc_q;

endmodule

// File: rtl/core/nwa_checker.sv
// Port-level checker for the automaton word acceptor, bound to the top level.
// Depends on nwa_pkg and nfa_word_acceptor_core.
`timescale 1ns / 1ps

module nwa_checker import nwa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push_i,
  input logic               full_o,
  input logic [ModeW-1:0]   mode_i,
  input logic               last_i,
  input logic               empty_o,
  input logic               pop_i,
  input logic               accepted_o
);

  logic [2:0] pending_q, pending_d;
  logic       word_end;
  logic       res_take;

  // Words pushed but whose result has not yet been taken.
  assign word_end = push_i && !full_o && (mode_i == MODE_SYM) && last_i;
  assign res_take = pop_i && !empty_o;

  always_comb begin
    pending_d = pending_q;
    if (word_end && !res_take) begin
      pending_d = pending_q + 1'b1;
    end else if (res_take && !word_end) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Reset leaves both queues empty.
  assert property (@(posedge clk_i) !rst_ni |=> empty_o && !full_o)
    else $error("queues not empty after reset");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(accepted_o))
    else $error("result changed while waiting");

  // A result only exists for a word that has ended and not been answered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> pending_q != 3'd0)
    else $error("result without a finished word");

endmodule

bind nfa_word_acceptor_core nwa_checker u_checker (.*);

// File: tb/nfa_word_acceptor_core_test.sv
// Self-checking test of nfa_word_acceptor_core: a queue-fed driver, a monitor and an
// automaton predictor that tracks the set of live states word by word.
// Depends on nwa_pkg and the RTL of nfa_word_acceptor_core.
`timescale 1ns / 1ps

module nfa_word_acceptor_core_test;
  import nwa_pkg::*;

  // Mode code that the block has no use for.
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
  localparam int LongHoldCycles = 400;
  localparam int MaxPrinted     = 50;

  typedef struct {
    logic [ModeW-1:0]   mode;
    logic [StateW-1:0]  from_s;
    logic [StateW-1:0]  to_s;
    logic [LetterW-1:0] letter;
    logic               last;
    bit                 drain_first;
  } nfa_item_t;

  // Block ports, all known from time zero.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push_i = 1'b0;
  logic                full_o;
  logic [ModeW-1:0]    mode_i = '0;
  logic [StateW-1:0]   from_state_i = '0;
  logic [StateW-1:0]   to_state_i = '0;
  logic [LetterW-1:0]  letter_i = '0;
  logic                last_i = 1'b0;
  logic                empty_o;
  logic                pop_i = 1'b0;
  logic                accepted_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Items still to be sent and verdicts still to arrive.
  nfa_item_t pending_q[$];
  logic      verdict_q[$];
  int        error_count = 0;
  int        items_built = 0;

  // Idling controls set per phase by the stimulus.
  bit sender_gaps_on = 1'b1;
  bit receiver_gaps_on = 1'b1;
  int long_hold_req = 0;

  // Predictor copy of the automaton and its registers.
  logic [StateW-1:0]  tbl_src [MaxEdges];
  logic [StateW-1:0]  tbl_tgt [MaxEdges];
  logic [LetterW-1:0] tbl_let [MaxEdges];
  int                 edge_total = 0;
  logic [SetW-1:0]    live_set = '0;
  bit                 mid_word = 1'b0;
  logic [StateW-1:0]  cfg_start = '0;
  logic [SetW-1:0]    cfg_final = '0;

  nfa_word_acceptor_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .mode_i      (mode_i),
    .from_state_i(from_state_i),
    .to_state_i  (to_state_i),
    .letter_i    (letter_i),
    .last_i      (last_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .accepted_o  (accepted_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Fixed limit on the whole run.
  initial begin
    #12_000_000;
    $display("nfa_word_acceptor_core: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endtask

  // Applies one accepted item to the automaton copy; a last symbol yields a verdict.
  function automatic void advance_automaton(input nfa_item_t it);
    logic [SetW-1:0] reached;
    reached = '0;
    if (it.mode == MODE_ADD) begin
      if (edge_total < MaxEdges && int'(it.from_s) < NumStates &&
          int'(it.to_s) < NumStates) begin
        tbl_src[edge_total] = it.from_s;
        tbl_tgt[edge_total] = it.to_s;
        tbl_let[edge_total] = it.letter;
        edge_total++;
      end
    end else if (it.mode == MODE_CLR) begin
      edge_total = 0;
    end else if (it.mode == MODE_SYM) begin
      // A fresh word starts from the start state alone.
      if (!mid_word) begin
        live_set = '0;
        if (int'(cfg_start) < NumStates) begin
          live_set[cfg_start] = 1'b1;
        end
      end
      for (int i = 0; i < edge_total; i++) begin
        if (tbl_let[i] == it.letter && live_set[tbl_src[i]]) begin
          reached[tbl_tgt[i]] = 1'b1;
        end
      end
      live_set = reached;
      if (it.last) begin
        mid_word = 1'b0;
        verdict_q = {verdict_q, |(live_set & cfg_final)};
      end else begin
        mid_word = 1'b1;
      end
    end
  endfunction

  // Driver: offers the head of the pending queue, with a drawn gap after each item.
  nfa_item_t offered;
  bit        offering = 1'b0;
  int        send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (offering && !full_o) begin
        advance_automaton(offered);
        offering = 1'b0;
        send_gap = sender_gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && verdict_q.size() != 0)) begin
          offered = pending_q.pop_front();
          offering = 1'b1;
          mode_i       <= offered.mode;
          from_state_i <= offered.from_s;
          to_state_i   <= offered.to_s;
          letter_i     <= offered.letter;
          last_i       <= offered.last;
        end
      end
      push_i <= offering;
    end
  end

  // Monitor: takes results with drawn stalls and checks them in order.
  bit taking = 1'b0;
  int take_stall = 0;
  int long_hold_done = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (taking && !empty_o) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("result arrived with no word outstanding");
        end else if (accepted_o !== verdict_q[0]) begin
          flag_mismatch($sformatf("accepted %b, predicted %b", accepted_o, verdict_q[0]));
          void'(verdict_q.pop_front());
        end else begin
          void'(verdict_q.pop_front());
        end
        taking = 1'b0;
        take_stall = receiver_gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (long_hold_done != long_hold_req) begin
        long_hold_done = long_hold_req;
        taking = 1'b0;
        take_stall = LongHoldCycles;
      end
      if (!taking) begin
        if (take_stall > 0) begin
          take_stall--;
        end else begin
          taking = 1'b1;
        end
      end
      pop_i <= taking;
    end
  end

  task automatic add_item(input logic [ModeW-1:0] mode, input logic [StateW-1:0] from_s,
                          input logic [StateW-1:0] to_s, input logic [LetterW-1:0] letter,
                          input logic last, input bit drain_first);
    nfa_item_t it;
    it.mode = mode;
    it.from_s = from_s;
    it.to_s = to_s;
    it.letter = letter;
    it.last = last;
    it.drain_first = drain_first;
    pending_q = {pending_q, it};
    items_built++;
  endtask

  // Symbol item with don't-care transition fields.
  task automatic add_symbol(input logic [LetterW-1:0] letter, input logic last,
                            input bit drain_first);
    add_item(MODE_SYM, StateW'($urandom), StateW'($urandom), letter, last, drain_first);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_START_STATE) begin
      cfg_start = value[StateW-1:0];
    end else begin
      cfg_final = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every item is sent and every verdict is in, then lets the table scan finish.
  task automatic settle();
    while (pending_q.size() != 0 || push_i || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MaxEdges + 8) @(posedge clk_i);
  endtask

  // One random phase: a fresh table over a small alphabet, then mostly words.
  task automatic build_phase(input bit big_table, input int budget);
    logic [LetterW-1:0] alpha [3];
    logic [LetterW-1:0] sym;
    int                 n_edges;
    int                 first_item;
    int                 len;
    int                 pick;
    bit                 open_word;
    first_item = items_built;
    open_word = 1'b0;
    foreach (alpha[k]) begin
      alpha[k] = LetterW'($urandom);
    end
    add_item(MODE_CLR, StateW'($urandom), StateW'($urandom), LetterW'($urandom),
             1'($urandom), 1'b0);
    // A big table can run past capacity, so that later additions are dropped.
    n_edges = big_table ? $urandom_range(60, 72) : $urandom_range(1, 14);
    for (int e = 0; e < n_edges; e++) begin
      add_item(MODE_ADD, ($urandom_range(0, 2) == 0) ? cfg_start : StateW'($urandom),
               StateW'($urandom), alpha[$urandom_range(0, 2)], 1'($urandom), 1'b0);
    end
    while (items_built - first_item < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) begin
          sym = ($urandom_range(0, 9) == 0) ? LetterW'($urandom) : alpha[$urandom_range(0, 2)];
          add_symbol(sym, j == len - 1, j == 0 && $urandom_range(0, 29) == 0);
          // Now and then the table changes between two symbols of a word.
          if (j < len - 1 && $urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              add_item(MODE_CLR, StateW'($urandom), StateW'($urandom), LetterW'($urandom),
                       1'($urandom), 1'b0);
            end else begin
              add_item(MODE_ADD, StateW'($urandom), StateW'($urandom),
                       alpha[$urandom_range(0, 2)], 1'($urandom), 1'b0);
            end
          end
        end
        open_word = 1'b0;
      end else if (pick < 86) begin
        add_item(MODE_ADD, StateW'($urandom), StateW'($urandom),
                 ($urandom_range(0, 1) == 0) ? alpha[$urandom_range(0, 2)] : LetterW'($urandom),
                 1'($urandom), 1'b0);
      end else if (pick < 90) begin
        add_item(MODE_CLR, StateW'($urandom), StateW'($urandom), LetterW'($urandom),
                 1'($urandom), 1'b0);
      end else if (pick < 95) begin
        add_item(MODE_SPARE, StateW'($urandom), StateW'($urandom), LetterW'($urandom),
                 1'($urandom), 1'b0);
      end else begin
        add_symbol(alpha[$urandom_range(0, 2)], 1'b0, 1'b0);
        open_word = 1'b1;
      end
    end
    // Close a word left open so that no word spans a register change.
    if (open_word) begin
      add_symbol(alpha[0], 1'b1, 1'b0);
    end
  endtask

  // Stimulus: reset, directed checks, then random phases under several settings.
  initial begin : stimulus
    logic [StateW-1:0]   start_val;
    logic [CfgDataW-1:0] mask_val;
    logic [CfgDataW-1:0] word_val;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(CFG_START_STATE, 16'h0000);
    write_reg(CFG_FINAL_MASK, 16'h8002);

    // A word on an empty table is rejected.
    add_symbol(8'h00, 1'b1, 1'b0);
    // Edges at the letter extremes; the last bit means nothing on an addition.
    add_item(MODE_ADD, 4'd0, 4'd1, 8'h00, 1'b1, 1'b0);
    add_item(MODE_ADD, 4'd1, 4'd15, 8'hFF, 1'b0, 1'b0);
    add_item(MODE_ADD, 4'd15, 4'd15, 8'hFF, 1'b0, 1'b0);
    add_item(MODE_ADD, 4'd0, 4'd0, 8'hAA, 1'b0, 1'b0);
    add_symbol(8'h00, 1'b0, 1'b0);
    add_symbol(8'hFF, 1'b0, 1'b0);
    add_symbol(8'hFF, 1'b1, 1'b0);
    // One-symbol word.
    add_symbol(8'h00, 1'b1, 1'b1);
    // The unused mode is ignored, whatever its fields.
    add_item(MODE_SPARE, 4'hF, 4'hF, 8'hFF, 1'b1, 1'b0);
    // An edge added in mid-word counts from the next symbol.
    add_symbol(8'hAA, 1'b0, 1'b0);
    add_item(MODE_ADD, 4'd0, 4'd2, 8'h55, 1'b0, 1'b0);
    add_symbol(8'h55, 1'b1, 1'b0);
    // A clear in mid-word leaves the word running on an empty table.
    add_symbol(8'hAA, 1'b0, 1'b0);
    add_item(MODE_CLR, 4'hF, 4'h0, 8'h00, 1'b1, 1'b0);
    add_symbol(8'hAA, 1'b1, 1'b0);
    add_item(MODE_ADD, 4'd0, 4'd15, 8'h5A, 1'b0, 1'b0);
    add_symbol(8'h5A, 1'b1, 1'b0);
    add_symbol(8'hA5, 1'b1, 1'b0);
    settle();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin start_val = 4'd0;  mask_val = 16'h0000; end
        1: begin start_val = 4'd15; mask_val = 16'hFFFF; end
        2: begin start_val = 4'd0;  mask_val = 16'hFFFF; end
        3: begin start_val = 4'd15; mask_val = 16'h0001; end
        default: begin
          start_val = StateW'($urandom);
          mask_val = CfgDataW'($urandom) | CfgDataW'($urandom);
        end
      endcase
      word_val = CfgDataW'($urandom);
      word_val[StateW-1:0] = start_val;
      write_reg(CFG_START_STATE, word_val);
      write_reg(CFG_FINAL_MASK, mask_val);
      sender_gaps_on = (ph % 3 != 1);
      receiver_gaps_on = (ph % 4 != 2);
      // Hold results back while items keep coming, so that the input backs up.
      if (ph == 5) begin
        sender_gaps_on = 1'b0;
        long_hold_req++;
      end
      build_phase(ph == 2 || ph == 9, 100);
      settle();
    end

    if (verdict_q.size() != 0) begin
      flag_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end
    if (error_count == 0) begin
      $display("nfa_word_acceptor_core: match");
    end else begin
      $display("nfa_word_acceptor_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/nwa_pkg.sv
rtl/core/nwa_front.sv
rtl/core/nwa_back.sv
rtl/core/nfa_word_acceptor_core.sv
rtl/core/nwa_checker.sv
tb/nfa_word_acceptor_core_test.sv
